// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked property, switched off while reset is high
`define ASSERT_DIS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked property, checked on every edge
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_DIS(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/blstk_pkg.sv =====
// ----------------------------------------------------------------------------
// blstk_pkg
// Shared constants, codes and handshake structs of the bounded LIFO stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package blstk_pkg;

   localparam int DEPTH  = 8;
   localparam int WORD_W = 32;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [2:0] {
      MODE_PUSH = 3'd0,
      MODE_POP  = 3'd1,
      MODE_PEEK = 3'd2,
      MODE_LIST = 3'd3,
      MODE_MAX  = 3'd4,
      MODE_EVEN = 3'd5,
      MODE_ODD  = 3'd6,
      MODE_RSVD = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_NONE  = 2'd3
   } status_type;

   typedef enum logic {
      CTL_IDLE = 1'b0,
      CTL_RUN  = 1'b1
   } ctl_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;   // capture a new transaction
      logic step;   // perform one step of the held operation
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic slot_free;   // output register can take a result this cycle
      logic done;        // current step finishes the operation
   } stat_type;

endpackage

`default_nettype wire

// ===== hw/rtl/blstk_ctrl.sv =====
// ----------------------------------------------------------------------------
// blstk_ctrl
// Controller: accepts one transaction, then steps the datapath until done.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module blstk_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  blstk_pkg::stat_type stat,
   output blstk_pkg::cmd_type  cmd
);
   import blstk_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd.load  = 1'b0;
      cmd.step  = 1'b0;
      case (state_ff)
         CTL_IDLE: begin
            // hold off the input while reset is high
            req_ready = !reset;
            cmd.load  = req_valid && !reset;
            if (req_valid) begin
               state_in = CTL_RUN;
            end
         end
         CTL_RUN: begin
            // advance only when the output register can take a result
            cmd.step = stat.slot_free;
            if (stat.slot_free && stat.done) begin
               state_in = CTL_IDLE;
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/blstk_dp.sv =====
// ----------------------------------------------------------------------------
// blstk_dp
// Datapath: entry store, fill count, scan pointer, running maximum and the
// registered result stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module blstk_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  blstk_pkg::cmd_type                  cmd,
   output blstk_pkg::stat_type                 stat,
   input  logic [2:0]                          req_mode,
   input  logic signed [blstk_pkg::WORD_W-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic signed [blstk_pkg::WORD_W-1:0] rsp_data,
   output logic [blstk_pkg::CNT_W-1:0]         rsp_count,
   output logic [blstk_pkg::CNT_W-1:0]         rsp_free_space,
   output logic                                rsp_last
);
   import blstk_pkg::*;

   logic signed [WORD_W-1:0] store_ff [DEPTH];
   logic [CNT_W-1:0]         fill_ff;
   logic [CNT_W-1:0]         fill_in;
   logic [IDX_W-1:0]         idx_ff;
   logic [IDX_W-1:0]         idx_in;
   logic signed [WORD_W-1:0] best_ff;
   logic signed [WORD_W-1:0] best_in;
   mode_type                 mode_ff;
   logic signed [WORD_W-1:0] value_ff;

   logic                     rsp_valid_ff;
   status_type               rsp_status_ff;
   logic signed [WORD_W-1:0] rsp_data_ff;
   logic [CNT_W-1:0]         rsp_count_ff;
   logic [CNT_W-1:0]         rsp_free_ff;
   logic                     rsp_last_ff;

   logic [IDX_W-1:0]         top_idx;
   logic signed [WORD_W-1:0] cur_word;
   logic signed [WORD_W-1:0] top_word;
   logic                     want_odd;
   logic [DEPTH-1:0]         match_vec;
   logic [DEPTH-1:0]         later_vec;
   logic                     any_match;
   logic                     later_match;
   logic                     at_end;
   logic                     wr_en;
   logic                     emit;
   logic                     done_c;
   status_type               st_c;
   logic signed [WORD_W-1:0] data_c;
   logic                     last_c;

   // scan support: match of each held entry and which entries lie above the pointer
   always_comb begin
      top_idx  = IDX_W'(fill_ff - CNT_W'(1));
      cur_word = store_ff[idx_ff];
      top_word = store_ff[top_idx];
      want_odd = (mode_ff == MODE_ODD);
      for (int j = 0; j < DEPTH; j++) begin
         match_vec[j] = (CNT_W'(j) < fill_ff) && (store_ff[j][0] == want_odd);
         later_vec[j] = (IDX_W'(j) > idx_ff);
      end
      any_match   = |match_vec;
      later_match = |(match_vec & later_vec);
      at_end      = (idx_ff == top_idx);
   end

   always_comb begin
      emit    = 1'b0;
      done_c  = 1'b1;
      st_c    = STAT_OK;
      data_c  = '0;
      last_c  = 1'b1;
      fill_in = fill_ff;
      wr_en   = 1'b0;
      best_in = best_ff;
      idx_in  = IDX_W'(idx_ff + IDX_W'(1));
      case (mode_ff)
         MODE_PUSH: begin
            emit = 1'b1;
            if (fill_ff == CNT_W'(DEPTH)) begin
               st_c = STAT_FULL;
            end else begin
               wr_en   = 1'b1;
               fill_in = CNT_W'(fill_ff + CNT_W'(1));
            end
         end
         MODE_RSVD: begin
            emit = 1'b1;
         end
         default: begin
            if (fill_ff == '0) begin
               emit = 1'b1;
               st_c = STAT_EMPTY;
            end else begin
               case (mode_ff)
                  MODE_POP: begin
                     emit    = 1'b1;
                     data_c  = top_word;
                     fill_in = CNT_W'(fill_ff - CNT_W'(1));
                  end
                  MODE_PEEK: begin
                     emit   = 1'b1;
                     data_c = top_word;
                  end
                  MODE_LIST: begin
                     emit   = 1'b1;
                     data_c = cur_word;
                     last_c = at_end;
                     done_c = at_end;
                  end
                  MODE_MAX: begin
                     if ((idx_ff == '0) || (cur_word > best_ff)) begin
                        best_in = cur_word;
                     end
                     emit   = at_end;
                     data_c = best_in;
                     done_c = at_end;
                  end
                  MODE_EVEN, MODE_ODD: begin
                     if (!any_match) begin
                        emit = 1'b1;
                        st_c = STAT_NONE;
                     end else begin
                        // last flag: no matching entry left above the pointer
                        emit   = match_vec[idx_ff];
                        data_c = cur_word;
                        last_c = !later_match;
                        done_c = match_vec[idx_ff] && !later_match;
                     end
                  end
                  default: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.step) begin
            fill_ff <= fill_in;
         end
         if (cmd.step && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= mode_type'(req_mode);
         value_ff <= req_value;
         idx_ff   <= '0;
      end else if (cmd.step) begin
         idx_ff  <= idx_in;
         best_ff <= best_in;
      end
      if (cmd.step && wr_en) begin
         store_ff[fill_ff[IDX_W-1:0]] <= value_ff;
      end
      if (cmd.step && emit) begin
         rsp_status_ff <= st_c;
         rsp_data_ff   <= data_c;
         rsp_count_ff  <= fill_in;
         rsp_free_ff   <= CNT_W'(CNT_W'(DEPTH) - fill_in);
         rsp_last_ff   <= last_c;
      end
   end

   assign stat.slot_free = !rsp_valid_ff || rsp_ready;
   assign stat.done      = done_c;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_data       = rsp_data_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_free_space = rsp_free_ff;
   assign rsp_last       = rsp_last_ff;

   `ASSERT_DIS(a_fill_bound, clock, reset, fill_ff <= CNT_W'(DEPTH), "fill count above depth")
   `ASSERT_DIS(a_count_sum, clock, reset, rsp_valid_ff |-> (CNT_W'(rsp_count_ff + rsp_free_ff) == CNT_W'(DEPTH)), "count and free space disagree")
   `ASSERT_DIS(a_pop_drop, clock, reset, (cmd.step && mode_ff == MODE_POP && fill_ff != '0) |=> (fill_ff == CNT_W'($past(fill_ff) - CNT_W'(1))), "pop did not drop one entry")

endmodule

`default_nettype wire

// ===== hw/rtl/bounded_lifo_stack_with_scans.sv =====
// The first step runs once the controller is in its run state and the result register is
// free; push, pop, peek and the empty, full and none-found cases give their single result
// from that step. Scans step one entry per cycle: listing and maximum visit every held entry,
// the odd/even listings stop at the last match; a stalled result output holds the scan pointer.
// Throughput: one transaction at a time; the next is accepted on the cycle after the last step.
// Reset (synchronous, active high) empties the stack and drops any pending result; entries stay.
// ----------------------------------------------------------------------------
// bounded_lifo_stack_with_scans
// Eight-deep stack of signed words with push, pop, peek, listing, maximum and odd/even scans.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bounded_lifo_stack_with_scans (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [2:0]                          req_mode,
   input  logic signed [blstk_pkg::WORD_W-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic signed [blstk_pkg::WORD_W-1:0] rsp_data,
   output logic [blstk_pkg::CNT_W-1:0]         rsp_count,
   output logic [blstk_pkg::CNT_W-1:0]         rsp_free_space,
   output logic                                rsp_last
);
   import blstk_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   blstk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   blstk_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_mode       (req_mode),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_data       (rsp_data),
      .rsp_count      (rsp_count),
      .rsp_free_space (rsp_free_space),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire
